FILE: sv/mtg_pkg.sv
package mtg_pkg;

	localparam int unsigned MT_N = 624;
	localparam int unsigned MT_M = 397;
	localparam int unsigned ADDR_W = 10;

	localparam logic [31:0] MT_MATRIX    = 32'h9908_B0DF;
	localparam logic [31:0] MT_UPPER     = 32'h8000_0000;
	localparam logic [31:0] MT_LOWER     = 32'h7FFF_FFFF;
	localparam logic [31:0] MT_TEMPER_B  = 32'h9D2C_5680;
	localparam logic [31:0] MT_TEMPER_C  = 32'hEFC6_0000;
	localparam logic [31:0] MT_SEED_MULT = 32'd69069;
	localparam logic [31:0] MT_SEED_RST  = 32'd4357;

	localparam logic [ADDR_W-1:0] POS_LAST = ADDR_W'(MT_N - 1);
	localparam logic [ADDR_W-1:0] POS_WRAP = ADDR_W'(MT_N - MT_M);
	localparam logic [ADDR_W-1:0] POS_OFS  = ADDR_W'(MT_M);

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_ISSUE,
		ST_FETCH,
		ST_CALC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        we;
		addr_t       waddr;
		logic [31:0] wdata;
		logic        re;
		addr_t       raddr_a;
		addr_t       raddr_b;
	} ram_ctrl_t;

endpackage

FILE: sv/mtg_if.sv
interface mtg_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface mtg_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

FILE: sv/mersenne_twister_generator.sv
// MT19937 generator, 32-bit words, older seeding (word0 = seed | 1, then
// each word = previous * 69069). Each request word returns one tempered
// word. The 624-word state sits in a two-read, one-write RAM and is twisted
// one word per draw, just before that word is issued. A plain draw goes
// through ISSUE and FETCH (RAM reads of words i and i+397, then i+1), CALC
// (twist and temper) and DONE, which loads the output register once it is
// free; requests are taken only in IDLE. A reseed (restart set, or the first
// request after reset) first writes all 624 state words, one per cycle
// through the seed multiplier from the seed last written on seed_we.
module mersenne_twister_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed_value,
	mtg_req_if.sink     req,
	mtg_word_if.source  rsp
);
	import mtg_pkg::*;

	state_t      state_q;
	state_t      state_nx;
	logic [31:0] seed_q;
	logic        seeded_q;
	addr_t       pos_q;
	addr_t       idx_q;
	logic [31:0] x_q;
	logic [31:0] cur_s1;
	logic [31:0] mid_s1;
	logic [31:0] word_q;
	logic        rsp_valid_q;
	logic [31:0] rsp_word_q;

	ram_ctrl_t   ram_ctrl;
	logic [31:0] rd_a;
	logic [31:0] rd_b;
	logic [31:0] new_word;
	logic [31:0] tempered;
	logic [31:0] seed_prod;
	addr_t       pos_nxt;
	addr_t       pos_mid;
	logic        req_acc;
	logic        out_free;

	mtg_ram u_ram (
		.clk  (clk),
		.ctrl (ram_ctrl),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	mtg_twist u_twist (
		.cur_word (cur_s1),
		.nxt_word (rd_a),
		.mid_word (mid_s1),
		.new_word (new_word),
		.tempered (tempered)
	);

	assign req.ready       = (state_q == ST_IDLE);
	assign req_acc         = req.valid & req.ready;
	assign out_free        = !rsp_valid_q || rsp.ready;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.random_word = rsp_word_q;

	assign pos_nxt   = (pos_q == POS_LAST) ? '0 : pos_q + addr_t'(1);
	assign pos_mid   = (pos_q >= POS_WRAP) ? pos_q - POS_WRAP : pos_q + POS_OFS;
	assign seed_prod = x_q * MT_SEED_MULT;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_nx = (req.restart || !seeded_q) ? ST_SEED : ST_ISSUE;
				end
			end
			ST_SEED: begin
				if (idx_q == POS_LAST) begin
					state_nx = ST_ISSUE;
				end
			end
			ST_ISSUE: state_nx = ST_FETCH;
			ST_FETCH: state_nx = ST_CALC;
			ST_CALC:  state_nx = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_ctrl = '0;
		unique case (state_q)
			ST_SEED: begin
				ram_ctrl.we    = 1'b1;
				ram_ctrl.waddr = idx_q;
				ram_ctrl.wdata = x_q;
			end
			ST_ISSUE: begin
				ram_ctrl.re      = 1'b1;
				ram_ctrl.raddr_a = pos_q;
				ram_ctrl.raddr_b = pos_mid;
			end
			ST_FETCH: begin
				ram_ctrl.re      = 1'b1;
				ram_ctrl.raddr_a = pos_nxt;
				ram_ctrl.raddr_b = pos_mid;
			end
			ST_CALC: begin
				// twisted word goes back in place; the next draw does not read it
				ram_ctrl.we    = 1'b1;
				ram_ctrl.waddr = pos_q;
				ram_ctrl.wdata = new_word;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= MT_SEED_RST;
			seeded_q    <= 1'b0;
			pos_q       <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (seed_we) begin
				seed_q <= seed_value;
			end
			if (state_q == ST_IDLE && req_acc && (req.restart || !seeded_q)) begin
				idx_q <= '0;
			end
			if (state_q == ST_SEED) begin
				idx_q <= idx_q + addr_t'(1);
				if (idx_q == POS_LAST) begin
					seeded_q <= 1'b1;
					pos_q    <= '0;
				end
			end
			if (state_q == ST_CALC) begin
				pos_q <= pos_nxt;
			end
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			x_q <= seed_q | 32'h1;
		end else if (state_q == ST_SEED) begin
			x_q <= seed_prod;
		end
		if (state_q == ST_FETCH) begin
			cur_s1 <= rd_a;
			mid_s1 <= rd_b;
		end
		if (state_q == ST_CALC) begin
			word_q <= tempered;
		end
		if (state_q == ST_DONE && out_free) begin
			rsp_word_q <= word_q;
		end
	end

endmodule

FILE: sv/mtg_ram.sv
module mtg_ram (
	input  logic              clk,
	input  mtg_pkg::ram_ctrl_t ctrl,
	output logic [31:0]       rd_a,
	output logic [31:0]       rd_b
);
	import mtg_pkg::*;

	logic [31:0] mem [MT_N];

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			mem[ctrl.waddr] <= ctrl.wdata;
		end
	end

	// read data holds between reads
	always_ff @(posedge clk) begin
		if (ctrl.re) begin
			rd_a <= mem[ctrl.raddr_a];
			rd_b <= mem[ctrl.raddr_b];
		end
	end

endmodule

FILE: sv/mtg_twist.sv
module mtg_twist (
	input  logic [31:0] cur_word,
	input  logic [31:0] nxt_word,
	input  logic [31:0] mid_word,
	output logic [31:0] new_word,
	output logic [31:0] tempered
);
	import mtg_pkg::*;

	logic [31:0] y;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] t3;

	always_comb begin
		y        = (cur_word & MT_UPPER) | (nxt_word & MT_LOWER);
		new_word = mid_word ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'h0);
		t1       = new_word ^ (new_word >> 11);
		t2       = t1 ^ ((t1 << 7) & MT_TEMPER_B);
		t3       = t2 ^ ((t2 << 15) & MT_TEMPER_C);
		tempered = t3 ^ (t3 >> 18);
	end

endmodule

FILE: bench/mersenne_twister_generator_tb.sv
module mersenne_twister_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtg_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned PHASE_WORDS   = 260;
	localparam int unsigned DIR_ROWS      = 20;

	typedef struct packed {
		logic        seed_wr;
		logic [31:0] seed;
		logic        restart;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        seed_we;
	logic [31:0] seed_wdata;

	mtg_req_if  req_ch ();
	mtg_word_if word_ch ();

	mersenne_twister_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_value (seed_wdata),
		.req        (req_ch),
		.rsp        (word_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------- generator model ----------------
	logic [31:0] mt_words [MT_N];
	int unsigned mt_pos;
	bit          mt_seeded;
	logic [31:0] seed_reg;

	logic [31:0] pending_words [$];
	int unsigned fail_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	function automatic void fill_state(logic [31:0] s);
		logic [31:0] x;
		x = s | 32'd1;
		mt_words[0] = x;
		for (int i = 1; i < MT_N; i++) begin
			x = x * MT_SEED_MULT;
			mt_words[i] = x;
		end
		mt_pos = 0;
		mt_seeded = 1'b1;
	endfunction

	function automatic void twist_block();
		logic [31:0] y;
		logic [31:0] v;
		for (int i = 0; i < MT_N; i++) begin
			y = (mt_words[i] & MT_UPPER) | (mt_words[(i + 1) % MT_N] & MT_LOWER);
			v = mt_words[(i + MT_M) % MT_N] ^ (y >> 1);
			if (y[0])
				v = v ^ MT_MATRIX;
			mt_words[i] = v;
		end
	endfunction

	function automatic logic [31:0] tempered(logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & MT_TEMPER_B);
		y = y ^ ((y << 15) & MT_TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [31:0] next_word(logic restart);
		logic [31:0] w;
		if (restart || !mt_seeded)
			fill_state(seed_reg);
		if (mt_pos >= MT_N)
			mt_pos = 0;
		if (mt_pos == 0)
			twist_block();
		w = tempered(mt_words[mt_pos]);
		mt_pos = (mt_pos + 1 >= MT_N) ? 0 : mt_pos + 1;
		return w;
	endfunction

	// model update and word check, all sampled at the clock edge
	always @(posedge clk) begin
		if (!arst_n) begin
			seed_reg = MT_SEED_RST;
			mt_pos = 0;
			mt_seeded = 1'b0;
			for (int i = 0; i < MT_N; i++)
				mt_words[i] = '0;
		end else begin
			if (seed_we)
				seed_reg = seed_wdata;
			if (req_ch.valid && req_ch.ready)
				pending_words.push_back(next_word(req_ch.restart));
			if (word_ch.valid && word_ch.ready) begin
				if (pending_words.size() == 0) begin
					$error("random_word: no word expected, got %h", word_ch.random_word);
					fail_count++;
				end else begin
					logic [31:0] want;
					want = pending_words.pop_front();
					if (word_ch.random_word !== want) begin
						$error("random_word: expected %h, got %h", want,
							word_ch.random_word);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk)
		word_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("mersenne_twister_generator: mismatch");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	// Leaves valid high after the request is taken; callers that pause lower it.
	task automatic push_request(input logic restart);
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.restart <= 1'($urandom_range(1));
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.restart <= restart;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// one edge first so the model has queued the last accepted request
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] s);
		seed_we <= 1'b1;
		seed_wdata <= s;
		@(posedge clk);
		seed_we <= 1'b0;
	endtask

	dir_row_t dir_rows [DIR_ROWS] = '{
		// first draw after reset seeds from the reset seed
		'{1'b0, 32'h0000_0000, 1'b0},
		'{1'b0, 32'h0000_0000, 1'b0},
		'{1'b0, 32'h0000_0000, 1'b1},
		'{1'b0, 32'h0000_0000, 1'b0},
		// seed write alone must not reseed
		'{1'b1, 32'h0000_0000, 1'b0},
		'{1'b0, 32'h0000_0000, 1'b0},
		'{1'b0, 32'h0000_0000, 1'b1},
		'{1'b0, 32'h0000_0000, 1'b0},
		'{1'b1, 32'hFFFF_FFFF, 1'b1},
		'{1'b0, 32'h0000_0000, 1'b0},
		// bit zero forced: same stream as seed 0
		'{1'b1, 32'h0000_0001, 1'b1},
		'{1'b1, 32'h8000_0000, 1'b1},
		'{1'b1, 32'hAAAA_AAAA, 1'b0},
		'{1'b0, 32'h0000_0000, 1'b1},
		'{1'b1, 32'h5555_5555, 1'b1},
		'{1'b0, 32'h0000_0000, 1'b0},
		'{1'b0, 32'h0000_0000, 1'b1},
		'{1'b0, 32'h0000_0000, 1'b1},
		'{1'b1, 32'h0000_1105, 1'b1},
		'{1'b1, 32'h0000_1104, 1'b1}
	};

	initial begin
		arst_n = 1'b0;
		seed_we = 1'b0;
		seed_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.restart = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].seed_wr) begin
				wait_drained();
				write_seed(dir_rows[r].seed);
			end
			push_request(dir_rows[r].restart);
		end

		// phases 0..2 run without reseeding after the first draw of phase 0, so the
		// position wraps past 624; the seeds written in phases 1 and 2 are never used
		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					write_seed($urandom);
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					write_seed(32'h0000_0000);
					send_idle_pct = 69;
					recv_stall_pct = 0;
				end
				2: begin
					write_seed(32'hFFFF_FFFF);
					send_idle_pct = 0;
					recv_stall_pct = 69;
				end
				default: begin
					write_seed($urandom);
					send_idle_pct = 27;
					recv_stall_pct = 27;
				end
			endcase
			for (int k = 0; k < PHASE_WORDS; k++)
				push_request((ph == 0 && k == 0) || (ph == 3 && $urandom_range(99) < 3));
		end

		wait_drained();
		if (fail_count == 0)
			$display("mersenne_twister_generator: match");
		else
			$display("mersenne_twister_generator: mismatch");
		$finish;
	end

endmodule
